// File: sv/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define DBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define DBR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/dbr_pkg.sv
// Package with types and constants of the 1-D depth buffer line rasterizer.
`timescale 1ns / 1ps
package dbr_pkg;

  // Width of a mapped column value, signed.
  localparam int CW = 35;

  localparam logic [31:0] DEPTH_RESET = 32'h7FFF_FFFF;
  localparam logic [15:0] NO_SEGMENT  = 16'hFFFF;
  localparam logic [15:0] COUNTER_MAX = 16'hFFFE;
  localparam logic [16:0] SEG_NONE_OUT = 17'h1_FFFF;
  localparam logic [5:0]  DIV_LAST    = 6'd32;

  // Configuration register indexes.
  localparam logic [1:0] REG_X_MIN       = 2'd0;
  localparam logic [1:0] REG_X_SCALE     = 2'd1;
  localparam logic [1:0] REG_KEEP_LARGER = 2'd2;

  typedef enum logic [1:0] {
    CMD_LINE  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } command_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_MAP_D,
    ST_MAP_M,
    ST_MAP_R,
    ST_ORDER,
    ST_SETUP,
    ST_DIV,
    ST_SKIP_M,
    ST_WALK_ST,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_RD_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic sweep_init;
    logic sweep_clear;
    logic map_d;
    logic map_m;
    logic map_r;
    logic order;
    logic setup;
    logic div_step;
    logic skip_m;
    logic walk_start;
    logic walk_rd;
    logic walk_wr;
    logic pix_rd;
    logic pix_wr;
    logic load_out;
    logic inc_ctr;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic end_b;
    logic outside;
    logic div_last;
    logic walk_last;
    logic col_ok;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: sv/dbr_ctrl.sv
// Controller state machine of the 1-D depth buffer line rasterizer.
`timescale 1ns / 1ps
module dbr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  input  dbr_pkg::ctrl_sts_t sts,
  output logic               in_stall,
  output dbr_pkg::ctrl_cmd_t cmd
);

  dbr_pkg::state_t state_r, state_nxt;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dbr_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      dbr_pkg::ST_INIT: begin
        cmd.sweep_init = 1'b1;
        if (sts.sweep_last) state_nxt = dbr_pkg::ST_IDLE;
      end
      dbr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (dbr_pkg::command_t'(in_command))
            dbr_pkg::CMD_LINE:  state_nxt = dbr_pkg::ST_MAP_D;
            dbr_pkg::CMD_PIXEL: state_nxt = sts.col_ok ? dbr_pkg::ST_PIX_RD : dbr_pkg::ST_IDLE;
            dbr_pkg::CMD_READ:  state_nxt = sts.col_ok ? dbr_pkg::ST_PIX_RD : dbr_pkg::ST_IDLE;
            dbr_pkg::CMD_CLEAR: state_nxt = dbr_pkg::ST_CLEAR;
            default:            state_nxt = dbr_pkg::ST_IDLE;
          endcase
        end
      end
      dbr_pkg::ST_CLEAR: begin
        cmd.sweep_clear = 1'b1;
        if (sts.sweep_last) state_nxt = dbr_pkg::ST_IDLE;
      end
      dbr_pkg::ST_MAP_D: begin
        cmd.map_d = 1'b1;
        state_nxt = dbr_pkg::ST_MAP_M;
      end
      dbr_pkg::ST_MAP_M: begin
        cmd.map_m = 1'b1;
        state_nxt = dbr_pkg::ST_MAP_R;
      end
      dbr_pkg::ST_MAP_R: begin
        cmd.map_r = 1'b1;
        state_nxt = sts.end_b ? dbr_pkg::ST_ORDER : dbr_pkg::ST_MAP_D;
      end
      dbr_pkg::ST_ORDER: begin
        cmd.order = 1'b1;
        state_nxt = dbr_pkg::ST_SETUP;
      end
      dbr_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.outside ? dbr_pkg::ST_IDLE : dbr_pkg::ST_DIV;
      end
      dbr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = dbr_pkg::ST_SKIP_M;
      end
      dbr_pkg::ST_SKIP_M: begin
        cmd.skip_m = 1'b1;
        state_nxt = dbr_pkg::ST_WALK_ST;
      end
      dbr_pkg::ST_WALK_ST: begin
        cmd.walk_start = 1'b1;
        state_nxt = dbr_pkg::ST_WALK_RD;
      end
      dbr_pkg::ST_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt = dbr_pkg::ST_WALK_WR;
      end
      dbr_pkg::ST_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        if (sts.walk_last) begin
          cmd.inc_ctr = 1'b1;
          state_nxt = dbr_pkg::ST_IDLE;
        end else begin
          state_nxt = dbr_pkg::ST_WALK_RD;
        end
      end
      dbr_pkg::ST_PIX_RD: begin
        cmd.pix_rd = 1'b1;
        state_nxt = sts.end_b ? dbr_pkg::ST_RD_OUT : dbr_pkg::ST_PIX_WR;
      end
      dbr_pkg::ST_PIX_WR: begin
        cmd.pix_wr = 1'b1;
        state_nxt = dbr_pkg::ST_IDLE;
      end
      dbr_pkg::ST_RD_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = dbr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dbr_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: sv/dbr_dp.sv
// Datapath of the 1-D depth buffer: mapping, divider, column walk and stores.
`timescale 1ns / 1ps
module dbr_dp #(
  parameter int COLUMNS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dbr_pkg::ctrl_cmd_t cmd,
  output dbr_pkg::ctrl_sts_t sts,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_x_start,
  input  logic signed [31:0] in_z_start,
  input  logic signed [31:0] in_x_end,
  input  logic signed [31:0] in_z_end,
  input  logic signed [15:0] in_column,
  input  logic signed [31:0] in_depth,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_depth_out,
  output logic signed [16:0] out_segment_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CW = dbr_pkg::CW;
  localparam logic [AW-1:0] LAST_COL = AW'(COLUMNS - 1);

  // Configuration registers.
  logic signed [31:0] x_min_r;
  logic [31:0]        x_scale_r;
  logic               keep_larger_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r       <= '0;
      x_scale_r     <= 32'h0001_0000;
      keep_larger_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dbr_pkg::REG_X_MIN:       x_min_r       <= cfg_data;
        dbr_pkg::REG_X_SCALE:     x_scale_r     <= cfg_data;
        dbr_pkg::REG_KEEP_LARGER: keep_larger_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Captured input beat.
  logic               is_read_r;
  logic signed [31:0] xs_r, zs_r, xe_r, ze_r, dep_r;
  logic signed [15:0] col_in_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_read_r <= (dbr_pkg::command_t'(in_command) == dbr_pkg::CMD_READ);
      xs_r      <= in_x_start;
      zs_r      <= in_z_start;
      xe_r      <= in_x_end;
      ze_r      <= in_z_end;
      col_in_r  <= in_column;
      dep_r     <= in_depth;
    end
  end

  assign sts.col_ok = !in_column[15] && ({17'b0, in_column[14:0]} < 32'(COLUMNS));

  // Column mapping: difference, magnitude, product, rounding.
  logic               end_sel_r;
  logic               neg_r;
  logic [32:0]        mag_r;
  logic [64:0]        prod_r;
  logic signed [CW-1:0] ca_r, cb_r;
  logic signed [32:0] diff_w;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [65:0]        rnd_w;
  logic [64:0]        tneg_w;
  logic [33:0]        mneg_w;
  logic signed [CW-1:0] col_w;

  assign diff_w = (end_sel_r ? {xe_r[31], xe_r} : {xs_r[31], xs_r}) - {x_min_r[31], x_min_r};

  // One shared 32x32 multiplier: scale product during mapping, clip skip later.
  logic signed [CW-1:0] cn_r, cf_r;
  logic [31:0]          factor_w;
  logic [32:0]          quo_r;

  assign factor_w = cn_r[CW-1] ? 32'(-cn_r) : 32'd0;
  assign mul_a    = cmd.skip_m ? quo_r[31:0] : mag_r[31:0];
  assign mul_b    = cmd.skip_m ? factor_w : x_scale_r;
  assign mul_p    = mul_a * mul_b;

  always_comb begin
    rnd_w  = {1'b0, prod_r} + 66'h0_8000_0000;
    tneg_w = prod_r - 65'h0_8000_0000;
    mneg_w = {1'b0, tneg_w[64:32]} + {33'b0, (tneg_w[31:0] != 32'd0)};
    if (!neg_r) begin
      col_w = $signed({1'b0, rnd_w[65:32]});
    end else if (prod_r <= 65'h0_8000_0000) begin
      col_w = '0;
    end else begin
      col_w = -$signed({1'b0, mneg_w});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      end_sel_r <= 1'b0;
    end else if (cmd.map_r) begin
      end_sel_r <= ~end_sel_r;
    end
    if (cmd.map_d) begin
      neg_r <= diff_w[32];
      mag_r <= diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
    end
    if (cmd.map_m) begin
      prod_r <= {1'b0, mul_p} + (mag_r[32] ? {1'b0, x_scale_r, 32'b0} : 65'd0);
    end else if (cmd.skip_m) begin
      prod_r <= {1'b0, mul_p};
    end
    if (cmd.map_r) begin
      if (end_sel_r) cb_r <= col_w;
      else           ca_r <= col_w;
    end
  end

  // The read path reuses the end flag: a read beat goes straight to the output.
  assign sts.end_b = cmd.pix_rd ? is_read_r : end_sel_r;

  // Ordering of the ends, span setup and the clip test.
  logic signed [31:0] zn_r, zf_r;
  logic               dneg_r;
  logic [CW-1:0]      den_r;
  logic [CW-1:0]      rem_r;
  logic [5:0]         div_cnt_r;
  logic signed [32:0] dz_w;
  logic [CW:0]        rem_sh_w;
  logic               ge_w;

  assign dz_w     = {zf_r[31], zf_r} - {zn_r[31], zn_r};
  assign rem_sh_w = {rem_r, quo_r[32]};
  assign ge_w     = rem_sh_w >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.order) begin
      if (ca_r > cb_r) begin
        cn_r <= cb_r; zn_r <= ze_r;
        cf_r <= ca_r; zf_r <= zs_r;
      end else begin
        cn_r <= ca_r; zn_r <= zs_r;
        cf_r <= cb_r; zf_r <= ze_r;
      end
    end
    if (cmd.setup) begin
      dneg_r    <= dz_w[32];
      quo_r     <= dz_w[32] ? 33'(-dz_w) : 33'(dz_w);
      den_r     <= CW'(cf_r - cn_r);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      // Restoring division, one quotient bit a cycle.
      rem_r     <= ge_w ? CW'(rem_sh_w - {1'b0, den_r}) : CW'(rem_sh_w);
      quo_r     <= {quo_r[31:0], ge_w};
      div_cnt_r <= div_cnt_r + 6'd1;
    end
  end

  assign sts.outside  = cf_r[CW-1] || (cn_r >= $signed(CW'(COLUMNS)));
  assign sts.div_last = (div_cnt_r == dbr_pkg::DIV_LAST);

  // Column walk with the depth step.
  logic signed [31:0] step_r, z_r;
  logic [AW-1:0]      walk_col_r, walk_end_r;

  always_ff @(posedge clk) begin
    if (cmd.skip_m) begin
      step_r <= dneg_r ? -$signed(quo_r[31:0]) : $signed(quo_r[31:0]);
    end
    if (cmd.walk_start) begin
      z_r        <= zn_r + (dneg_r ? -$signed(prod_r[31:0]) : $signed(prod_r[31:0]));
      walk_col_r <= cn_r[CW-1] ? '0 : cn_r[AW-1:0];
      walk_end_r <= (cf_r > $signed(CW'(COLUMNS - 1))) ? LAST_COL : cf_r[AW-1:0];
    end else if (cmd.walk_wr) begin
      walk_col_r <= walk_col_r + 1'b1;
      z_r        <= z_r + step_r;
    end
  end

  assign sts.walk_last = (walk_col_r == walk_end_r);

  // Sweep counter for the reset pass and the clear command.
  logic [AW-1:0] sw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= '0;
    end else if (cmd.sweep_init || cmd.sweep_clear) begin
      sw_r <= (sw_r == LAST_COL) ? '0 : sw_r + 1'b1;
    end
  end

  assign sts.sweep_last = (sw_r == LAST_COL);

  // Line counter, saturating below the no-segment code.
  logic [15:0] ctr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (cmd.inc_ctr && (ctr_r != dbr_pkg::COUNTER_MAX)) begin
      ctr_r <= ctr_r + 16'd1;
    end
  end

  // Depth and segment stores.
  logic signed [31:0] depth_mem [COLUMNS];
  logic [15:0]        seg_mem [COLUMNS];
  logic signed [31:0] rd_depth_r;
  logic [15:0]        rd_seg_r;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               rd_en, wr_depth_en, wr_seg_en, win_w;
  logic signed [31:0] new_z, wr_depth;
  logic [15:0]        wr_seg;

  assign new_z = cmd.walk_wr ? z_r : dep_r;
  assign win_w = keep_larger_r ? (rd_depth_r < new_z) : (rd_depth_r > new_z);
  assign rd_en   = cmd.walk_rd || cmd.pix_rd;
  assign rd_addr = cmd.walk_rd ? walk_col_r : col_in_r[AW-1:0];

  always_comb begin
    wr_depth_en = 1'b0;
    wr_seg_en   = 1'b0;
    wr_addr     = sw_r;
    wr_depth    = dep_r;
    wr_seg      = ctr_r;
    if (cmd.sweep_init) begin
      wr_depth_en = 1'b1;
      wr_seg_en   = 1'b1;
      wr_depth    = dbr_pkg::DEPTH_RESET;
      wr_seg      = dbr_pkg::NO_SEGMENT;
    end else if (cmd.sweep_clear) begin
      wr_depth_en = 1'b1;
    end else if (cmd.walk_wr || cmd.pix_wr) begin
      wr_depth_en = win_w;
      wr_seg_en   = win_w;
      wr_addr     = cmd.walk_wr ? walk_col_r : col_in_r[AW-1:0];
      wr_depth    = new_z;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_depth_en) depth_mem[wr_addr] <= wr_depth;
    if (wr_seg_en)   seg_mem[wr_addr]   <= wr_seg;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_depth_r <= depth_mem[rd_addr];
      rd_seg_r   <= seg_mem[rd_addr];
    end
  end

  // Output register for read results.
  logic               out_valid_r;
  logic signed [31:0] out_depth_r;
  logic signed [16:0] out_seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_depth_r <= rd_depth_r;
      out_seg_r   <= (rd_seg_r == dbr_pkg::NO_SEGMENT) ? dbr_pkg::SEG_NONE_OUT
                                                       : {1'b0, rd_seg_r};
    end
  end

  assign sts.out_free    = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_depth_out   = out_depth_r;
  assign out_segment_out = out_seg_r;

endmodule

// File: sv/depth_buffer_1d_line_raster_top.sv
// Top level of the 1-D depth buffer line rasterizer.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  command, x/z ends, column, depth
//   out      output     out_valid/out_stall depth_out, segment_out
//   cfg      input      cfg_we             cfg_index, cfg_data
//
// A line takes the beat, maps both ends on the shared multiplier, orders and sets
// up, runs the bit-serial divider and the left clip, then does one read-modify-write
// of the stores per column. A pixel reads then writes its column, a read moves its
// column to the output, and a line wholly outside ends at setup.
// After reset the block sweeps both stores before taking a beat.
// A read result waits in the output register; a following read holds until it leaves.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module depth_buffer_1d_line_raster_top #(
  parameter int COLUMNS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_x_start,
  input  logic signed [31:0] in_z_start,
  input  logic signed [31:0] in_x_end,
  input  logic signed [31:0] in_z_end,
  input  logic signed [15:0] in_column,
  input  logic signed [31:0] in_depth,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_depth_out,
  output logic signed [16:0] out_segment_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  dbr_pkg::ctrl_cmd_t cmd;
  dbr_pkg::ctrl_sts_t sts;

  // Controller.
  dbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_command),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // Datapath and stores.
  dbr_dp #(
    .COLUMNS(COLUMNS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_command     (in_command),
    .in_x_start     (in_x_start),
    .in_z_start     (in_z_start),
    .in_x_end       (in_x_end),
    .in_z_end       (in_z_end),
    .in_column      (in_column),
    .in_depth       (in_depth),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_depth_out  (out_depth_out),
    .out_segment_out(out_segment_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // A new result only comes out of a read the block is still working on.
  `DBR_ASSERT(a_out_from_busy, $rose(out_valid) |-> $past(in_stall), "result without busy read")
  // An accepted line beat always keeps the block busy the next cycle.
  `DBR_ASSERT(a_line_busy, (in_valid && !in_stall && in_command == dbr_pkg::CMD_LINE) |=> in_stall, "line not taken")
  // A winning tag never carries the no-segment code.
  `DBR_ASSERT(a_tag_range, out_valid |-> (out_segment_out != {1'b0, dbr_pkg::NO_SEGMENT}), "bad segment tag")
  // Reset leaves the output channel empty.
  `DBR_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid, "output valid after reset")

endmodule
